### src/bsad_pkg.sv
// ----------------------------------------------------------------------------
// bsad_pkg: shared types and constants for the sensor advertisement decoder
// Holds the decoded record layout, the queue entry, the back-end states and
// the constants of the manufacturer-data formats.
// ----------------------------------------------------------------------------
package bsad_pkg;

    localparam int TAG_SLOTS_DEF = 16;

    localparam int CAP_DEPTH = 17;

    localparam logic [4:0] CNT_MAX       = 5'd31;
    localparam logic [4:0] MIN_LEN_HDR   = 5'd3;
    localparam logic [4:0] MIN_LEN_FMT5  = 5'd26;
    localparam logic [4:0] MIN_LEN_FMT3  = 5'd16;

    localparam logic [7:0] COMPANY_ID_LO = 8'h99;
    localparam logic [7:0] COMPANY_ID_HI = 8'h04;
    localparam logic [7:0] FMT_FIVE      = 8'd5;
    localparam logic [7:0] FMT_THREE     = 8'd3;

    localparam logic [15:0] TEMP_MISSING  = 16'h8000;
    localparam logic [15:0] RAW_MISSING   = 16'hFFFF;
    localparam logic [16:0] PRESS_OFFSET  = 17'd50000;
    localparam logic [10:0] BATT_UNKNOWN  = 11'd2047;
    localparam logic [15:0] BATT_OFFSET   = 16'd1600;
    localparam logic [15:0] FMT3_SCALE    = 16'd200;

    typedef struct packed {
        logic        is_format_five;
        logic        temp_valid;
        logic [15:0] temperature;
        logic        humidity_valid;
        logic [15:0] humidity;
        logic        pressure_valid;
        logic [16:0] pressure_pa;
        logic [15:0] battery_mv;
        logic [7:0]  signal_out;
    } t_record;

    typedef struct packed {
        logic        ok;
        t_record     rec;
        logic [47:0] addr;
        logic [31:0] now_ms;
    } t_job;

    typedef struct packed {
        logic        stored;
        logic [3:0]  slot_index;
        t_record     rec;
    } t_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_WRITE,
        BK_DONE
    } t_back_state;

endpackage

### src/bsad_ram.sv
// ----------------------------------------------------------------------------
// bsad_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bsad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/bsad_queue.sv
// ----------------------------------------------------------------------------
// bsad_queue: two-entry queue between the packet front end and the table
// Decouples byte intake from the slot search so either side can stall.
// ----------------------------------------------------------------------------
module bsad_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bsad_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output bsad_pkg::t_job o_job,
    output logic          o_empty
);
    import bsad_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/bsad_front.sv
// ----------------------------------------------------------------------------
// bsad_front: byte intake, header check and fixed-point decode
// Captures the first bytes of each packet and, on the last byte, queues a
// decoded record together with the tag address and the time.
// ----------------------------------------------------------------------------
module bsad_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    input  logic [47:0]    i_tag_address,
    input  logic [7:0]     i_signal_strength,
    input  logic [31:0]    i_now_ms,
    input  logic           i_q_full,
    output logic           o_push,
    output bsad_pkg::t_job o_job
);
    import bsad_pkg::*;

    logic        r_enable;
    logic [4:0]  r_cnt;
    logic [7:0]  r_cap [CAP_DEPTH];

    logic        accept;
    logic [4:0]  n_cnt;
    logic [7:0]  v_byte [CAP_DEPTH];
    logic        hdr_ok;
    logic [15:0] raw_a;
    logic [15:0] raw_b;
    logic [15:0] raw_c;
    logic [15:0] raw_d;
    logic [10:0] batt_code;
    logic [15:0] mag;
    t_job        job;

    assign o_s_tready = ~i_q_full;
    assign accept     = i_s_tvalid & ~i_q_full;
    assign n_cnt      = (r_cnt < CNT_MAX) ? r_cnt + 5'd1 : CNT_MAX;

    always_comb begin
        for (int k = 0; k < CAP_DEPTH; k++) begin
            v_byte[k] = (r_cnt == 5'(k)) ? i_data_byte : r_cap[k];
        end
    end

    always_comb begin
        job       = '0;
        hdr_ok    = r_enable && (n_cnt >= MIN_LEN_HDR) &&
                    (v_byte[0] == COMPANY_ID_LO) && (v_byte[1] == COMPANY_ID_HI);
        raw_a     = '0;
        raw_b     = '0;
        raw_c     = '0;
        raw_d     = '0;
        batt_code = '0;
        mag       = '0;
        if (hdr_ok && v_byte[2] == FMT_FIVE && n_cnt >= MIN_LEN_FMT5) begin
            raw_a     = {v_byte[3], v_byte[4]};
            raw_b     = {v_byte[5], v_byte[6]};
            raw_c     = {v_byte[7], v_byte[8]};
            raw_d     = {v_byte[15], v_byte[16]};
            batt_code = raw_d[15:5];
            job.ok                 = 1'b1;
            job.rec.is_format_five = 1'b1;
            if (raw_a != TEMP_MISSING) begin
                job.rec.temp_valid  = 1'b1;
                job.rec.temperature = raw_a;
            end
            if (raw_b != RAW_MISSING) begin
                job.rec.humidity_valid = 1'b1;
                job.rec.humidity       = raw_b;
            end
            if (raw_c != RAW_MISSING) begin
                job.rec.pressure_valid = 1'b1;
                job.rec.pressure_pa    = {1'b0, raw_c} + PRESS_OFFSET;
            end
            job.rec.battery_mv = (batt_code != BATT_UNKNOWN) ?
                                 {5'd0, batt_code} + BATT_OFFSET : 16'd0;
        end else if (hdr_ok && v_byte[2] == FMT_THREE && n_cnt >= MIN_LEN_FMT3) begin
            raw_c = {v_byte[6], v_byte[7]};
            mag   = {9'd0, v_byte[4][6:0]} * FMT3_SCALE + {7'd0, v_byte[5], 1'b0};
            job.ok                 = 1'b1;
            job.rec.temp_valid     = 1'b1;
            job.rec.temperature    = v_byte[4][7] ? (16'd0 - mag) : mag;
            job.rec.humidity_valid = 1'b1;
            job.rec.humidity       = {8'd0, v_byte[3]} * FMT3_SCALE;
            job.rec.pressure_valid = 1'b1;
            job.rec.pressure_pa    = {1'b0, raw_c} + PRESS_OFFSET;
            job.rec.battery_mv     = {v_byte[14], v_byte[15]};
        end
        if (job.ok) begin
            job.rec.signal_out = i_signal_strength;
            job.addr           = i_tag_address;
            job.now_ms         = i_now_ms;
        end
    end

    assign o_push = accept & i_last_byte;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CAP_DEPTH; k++) begin
            if (accept && r_cnt == 5'(k)) begin
                r_cap[k] <= i_data_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_cnt    <= 5'd0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (accept) begin
                r_cnt <= i_last_byte ? 5'd0 : n_cnt;
            end
        end
    end

endmodule

### src/bsad_back.sv
// ----------------------------------------------------------------------------
// bsad_back: tag table and result output
// For a decoded packet, scans the slot table one slot per cycle for a
// matching address, the first free slot and the least recently seen slot,
// then writes the chosen slot; every packet's result is registered.
// ----------------------------------------------------------------------------
module bsad_back #(
    parameter int TAG_SLOTS = bsad_pkg::TAG_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  bsad_pkg::t_job    i_job,
    output logic              o_pop,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output bsad_pkg::t_result o_result
);
    import bsad_pkg::*;

    localparam int IW = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(TAG_SLOTS - 1);

    t_back_state r_state;
    t_back_state n_state;

    t_job        r_job;
    logic [IW-1:0] r_rd_idx;
    logic        r_rd_done;
    logic        r_cmp_valid;
    logic [IW-1:0] r_cmp_idx;
    logic        r_hit_found;
    logic [IW-1:0] r_hit_idx;
    logic        r_free_found;
    logic [IW-1:0] r_free_idx;
    logic        r_min_found;
    logic [IW-1:0] r_min_idx;
    logic [31:0] r_min_time;
    logic        r_used [TAG_SLOTS];
    logic [IW-1:0] r_slot;
    logic        r_out_valid;
    t_result     r_out;

    logic        pop;
    logic        ram_we;
    logic        load_out;
    logic [IW-1:0] pick;
    logic [79:0] ram_rdata;
    logic        used_c;

    assign pick = r_hit_found  ? r_hit_idx  :
                  r_free_found ? r_free_idx : r_min_idx;
    assign used_c = r_used[r_cmp_idx];

    bsad_ram #(
        .WIDTH (80),
        .DEPTH (TAG_SLOTS),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (pick),
        .i_wdata ({r_job.now_ms, r_job.addr}),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state  = r_state;
        pop      = 1'b0;
        ram_we   = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    pop     = 1'b1;
                    n_state = i_job.ok ? BK_SCAN : BK_DONE;
                end
            end
            BK_SCAN: begin
                if (r_cmp_valid && r_cmp_idx == LAST_SLOT) begin
                    n_state = BK_WRITE;
                end
            end
            BK_WRITE: begin
                ram_we  = 1'b1;
                n_state = BK_DONE;
            end
            BK_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job        <= i_job;
            r_rd_idx     <= '0;
            r_rd_done    <= 1'b0;
            r_cmp_valid  <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_min_found  <= 1'b0;
        end else if (r_state == BK_SCAN) begin
            r_cmp_valid <= ~r_rd_done;
            r_cmp_idx   <= r_rd_idx;
            if (!r_rd_done) begin
                if (r_rd_idx == LAST_SLOT) begin
                    r_rd_done <= 1'b1;
                end else begin
                    r_rd_idx <= r_rd_idx + IW'(1);
                end
            end
            if (r_cmp_valid) begin
                if (used_c && ram_rdata[47:0] == r_job.addr && !r_hit_found) begin
                    r_hit_found <= 1'b1;
                    r_hit_idx   <= r_cmp_idx;
                end
                if (!used_c && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
                if (used_c && (!r_min_found || ram_rdata[79:48] < r_min_time)) begin
                    r_min_found <= 1'b1;
                    r_min_idx   <= r_cmp_idx;
                    r_min_time  <= ram_rdata[79:48];
                end
            end
        end
        if (ram_we) begin
            r_slot <= pick;
        end
        if (load_out) begin
            r_out.stored     <= r_job.ok;
            r_out.slot_index <= r_job.ok ? 4'(r_slot) : 4'd0;
            r_out.rec        <= r_job.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAG_SLOTS; k++) begin
                r_used[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (ram_we) begin
                r_used[pick] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out;

endmodule

### src/ble_sensor_adv_decode_and_table.sv
// ----------------------------------------------------------------------------
// ble_sensor_adv_decode_and_table: sensor advertisement decoder and tag table
//
// Channel   Dir  Payload
// s_axis    in   tdata: data_byte, tag_address, signal_strength, now_ms;
//                tlast: last_byte
// m_axis    out  tdata: decoded record and slot; tuser: is_format_five
// cfg       in   decode_enable, written when i_cfg_we is high
//
// The front end takes one byte per cycle while the queue is not full; each
// last byte queues one packet. The back end reads the table RAM once per slot
// and then writes it for a decoded packet, and skips the scan for a rejected one.
// A two-entry queue lets bytes keep flowing during the slot scan; the input
// stalls only when the queue is full. Reset empties the table at once.
// ----------------------------------------------------------------------------
module ble_sensor_adv_decode_and_table #(
    parameter int TAG_SLOTS = bsad_pkg::TAG_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // data_byte[7:0], tag_address[55:8], signal_strength[63:56], now_ms[95:64]
    input  logic [95:0]  i_s_tdata,
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // stored[0], slot_index[4:1], temp_valid[5], temperature[21:6],
    // humidity_valid[22], humidity[38:23], pressure_valid[39],
    // pressure_pa[56:40], battery_mv[72:57], signal_out[80:73], zero[87:81]
    output logic [87:0]  o_m_tdata,
    // is_format_five[0]
    output logic         o_m_tuser
);
    import bsad_pkg::*;

    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    t_job    front_job;
    t_job    back_job;
    t_result result;

    bsad_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_s_tvalid        (i_s_tvalid),
        .o_s_tready        (o_s_tready),
        .i_data_byte       (i_s_tdata[7:0]),
        .i_last_byte       (i_s_tlast),
        .i_tag_address     (i_s_tdata[55:8]),
        .i_signal_strength (i_s_tdata[63:56]),
        .i_now_ms          (i_s_tdata[95:64]),
        .i_q_full          (q_full),
        .o_push            (push),
        .o_job             (front_job)
    );

    bsad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_job   (back_job),
        .o_empty (q_empty)
    );

    bsad_back #(
        .TAG_SLOTS (TAG_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_job      (back_job),
        .o_pop      (pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_result   (result)
    );

    assign o_m_tdata = {7'd0,
                        result.rec.signal_out,
                        result.rec.battery_mv,
                        result.rec.pressure_pa,
                        result.rec.pressure_valid,
                        result.rec.humidity,
                        result.rec.humidity_valid,
                        result.rec.temperature,
                        result.rec.temp_valid,
                        result.slot_index,
                        result.stored};
    assign o_m_tuser = result.rec.is_format_five;

endmodule

### tb/tb_ble_sensor_adv_decode_and_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ble_sensor_adv_decode_and_table: self-checking bench for the decoder
// Streams manufacturer-data packets byte by byte, first a list of hand-made
// cases and then random packets, in phases with decoding on and off. A
// behavioral copy of the decoder and its tag table predicts every record,
// and each record that leaves the block is compared with the oldest
// prediction. Both stream sides idle at random, and the record side holds
// off for a long stretch once so that the block stalls its input.
// ----------------------------------------------------------------------------
module tb_ble_sensor_adv_decode_and_table;

    import bsad_pkg::*;

    localparam int SETTLE_CYCLES = 2 * (TAG_SLOTS_DEF + 4) + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 3000;
    localparam int TOTAL_BYTES   = 1300;
    localparam int POOL_SIZE     = 24;
    localparam int MAX_PKT_LEN   = 48;

    typedef enum int {
        FLAW_ID_LO,
        FLAW_ID_HI,
        FLAW_HDR_ONLY,
        FLAW_SHORT_FIVE,
        FLAW_SHORT_THREE,
        FLAW_ANY_FMT
    } t_flaw;

    typedef struct {
        bit          en;
        logic [7:0]  id0;
        logic [7:0]  id1;
        logic [7:0]  fmt;
        int          len;
        logic [15:0] v0;
        logic [15:0] v1;
        logic [15:0] v2;
        logic [15:0] v3;
        logic [47:0] addr;
        logic [7:0]  rssi;
        logic [31:0] now_ms;
        bit          has_exp;
        t_result     exp;
    } t_adv;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [95:0] i_s_tdata   = '0;
    logic        i_s_tlast   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [87:0] o_m_tdata;
    logic        o_m_tuser;

    logic [4:0]  pkt_len_cnt = '0;
    logic [7:0]  pkt_bytes [CAP_DEPTH];
    bit          tag_used [TAG_SLOTS_DEF] = '{default: 1'b0};
    logic [47:0] tag_addr [TAG_SLOTS_DEF];
    logic [31:0] tag_seen [TAG_SLOTS_DEF];
    bit          decode_on = 1'b1;
    t_result     expected_records [$];

    t_adv        dir_cases [$];
    logic [47:0] tag_pool [POOL_SIZE];
    int          errors      = 0;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;
    bit          rx_hold_req = 1'b0;

    ble_sensor_adv_decode_and_table #(
        .TAG_SLOTS(TAG_SLOTS_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int gap_cycles(bit burst);
        int r;
        if (burst) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic string rec_str(t_result r);
        return $sformatf({"stored=%0d slot=%0d f5=%0d t=%0d/%0d h=%0d/%0d p=%0d/%0d ",
                          "bat=%0d rssi=%0d"},
                         r.stored, r.slot_index, r.rec.is_format_five,
                         r.rec.temp_valid, $signed(r.rec.temperature),
                         r.rec.humidity_valid, r.rec.humidity,
                         r.rec.pressure_valid, r.rec.pressure_pa,
                         r.rec.battery_mv, $signed(r.rec.signal_out));
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Decoder and tag table model, fed with every accepted byte.
    task automatic track_adv_byte(input logic [7:0] b, input bit last,
                                  input logic [47:0] addr, input logic [7:0] rssi,
                                  input logic [31:0] now_ms);
        logic [4:0]  n;
        logic [15:0] t;
        logic [15:0] h;
        logic [15:0] pr;
        logic [15:0] word;
        logic [15:0] mag;
        t_result     res;
        bit          ok;
        int          s;
        if (pkt_len_cnt < CAP_DEPTH) begin
            pkt_bytes[pkt_len_cnt] = b;
        end
        if (pkt_len_cnt != CNT_MAX) begin
            pkt_len_cnt++;
        end
        if (!last) begin
            return;
        end
        n = pkt_len_cnt;
        pkt_len_cnt = '0;
        res = '0;
        ok = 1'b0;
        if (decode_on && n >= MIN_LEN_HDR && pkt_bytes[0] == COMPANY_ID_LO &&
            pkt_bytes[1] == COMPANY_ID_HI) begin
            if (pkt_bytes[2] == FMT_FIVE && n >= MIN_LEN_FMT5) begin
                t    = {pkt_bytes[3], pkt_bytes[4]};
                h    = {pkt_bytes[5], pkt_bytes[6]};
                pr   = {pkt_bytes[7], pkt_bytes[8]};
                word = {pkt_bytes[15], pkt_bytes[16]};
                ok = 1'b1;
                res.rec.is_format_five = 1'b1;
                if (t != TEMP_MISSING) begin
                    res.rec.temp_valid  = 1'b1;
                    res.rec.temperature = t;
                end
                if (h != RAW_MISSING) begin
                    res.rec.humidity_valid = 1'b1;
                    res.rec.humidity       = h;
                end
                if (pr != RAW_MISSING) begin
                    res.rec.pressure_valid = 1'b1;
                    res.rec.pressure_pa    = {1'b0, pr} + PRESS_OFFSET;
                end
                if (word[15:5] != BATT_UNKNOWN) begin
                    res.rec.battery_mv = {5'd0, word[15:5]} + BATT_OFFSET;
                end
            end else if (pkt_bytes[2] == FMT_THREE && n >= MIN_LEN_FMT3) begin
                mag = {9'd0, pkt_bytes[4][6:0]} * FMT3_SCALE + {7'd0, pkt_bytes[5], 1'b0};
                ok = 1'b1;
                res.rec.temp_valid     = 1'b1;
                res.rec.temperature    = pkt_bytes[4][7] ? 16'd0 - mag : mag;
                res.rec.humidity_valid = 1'b1;
                res.rec.humidity       = {8'd0, pkt_bytes[3]} * FMT3_SCALE;
                res.rec.pressure_valid = 1'b1;
                res.rec.pressure_pa    = {1'b0, pkt_bytes[6], pkt_bytes[7]} + PRESS_OFFSET;
                res.rec.battery_mv     = {pkt_bytes[14], pkt_bytes[15]};
            end
            if (ok) begin
                s = -1;
                for (int i = 0; i < TAG_SLOTS_DEF; i++) begin
                    if (s < 0 && tag_used[i] && tag_addr[i] == addr) begin
                        s = i;
                    end
                end
                for (int i = 0; i < TAG_SLOTS_DEF; i++) begin
                    if (s < 0 && !tag_used[i]) begin
                        s = i;
                    end
                end
                if (s < 0) begin
                    s = 0;
                    for (int i = 1; i < TAG_SLOTS_DEF; i++) begin
                        if (tag_seen[i] < tag_seen[s]) begin
                            s = i;
                        end
                    end
                end
                tag_used[s] = 1'b1;
                tag_addr[s] = addr;
                tag_seen[s] = now_ms;
                res.stored = 1'b1;
                res.slot_index = s[3:0];
                res.rec.signal_out = rssi;
            end
        end
        expected_records.push_back(res);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last, input logic [47:0] addr,
                             input logic [7:0] rssi, input logic [31:0] now_ms,
                             input bit no_gaps);
        int gap;
        gap = gap_cycles(no_gaps);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {now_ms, rssi, addr, b};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        track_adv_byte(b, last, addr, rssi, now_ms);
        bytes_sent++;
    endtask

    task automatic send_packet(input t_adv p, input bit no_gaps);
        logic [7:0]  b [MAX_PKT_LEN];
        logic [47:0] junk_addr;
        logic [7:0]  junk_rssi;
        logic [31:0] junk_now;
        bit          quiet;
        quiet = no_gaps || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < MAX_PKT_LEN; i++) begin
            b[i] = $urandom;
        end
        b[0] = p.id0;
        b[1] = p.id1;
        b[2] = p.fmt;
        if (p.fmt == FMT_THREE) begin
            b[3] = p.v1[7:0];
            {b[4], b[5]}   = p.v0;
            {b[6], b[7]}   = p.v2;
            {b[14], b[15]} = p.v3;
        end else begin
            {b[3], b[4]}   = p.v0;
            {b[5], b[6]}   = p.v1;
            {b[7], b[8]}   = p.v2;
            {b[15], b[16]} = p.v3;
        end
        for (int i = 0; i < p.len; i++) begin
            if (i == p.len - 1) begin
                send_byte(b[i], 1'b1, p.addr, p.rssi, p.now_ms, quiet);
            end else begin
                junk_addr = {$urandom, $urandom};
                junk_rssi = $urandom;
                junk_now  = $urandom;
                send_byte(b[i], 1'b0, junk_addr, junk_rssi, junk_now, quiet);
            end
        end
        if (p.has_exp) begin
            expected_records[expected_records.size() - 1] = p.exp;
        end
    endtask

    task automatic add_row(input bit en, input logic [7:0] id0, input logic [7:0] id1,
                           input logic [7:0] fmt, input int len,
                           input logic [15:0] v0, v1, v2, v3,
                           input logic [47:0] addr, input logic [7:0] rssi,
                           input logic [31:0] now_ms,
                           input bit has_exp = 1'b0, input t_result exp = '0);
        t_adv p;
        p.en = en;
        p.id0 = id0;
        p.id1 = id1;
        p.fmt = fmt;
        p.len = len;
        p.v0 = v0;
        p.v1 = v1;
        p.v2 = v2;
        p.v3 = v3;
        p.addr = addr;
        p.rssi = rssi;
        p.now_ms = now_ms;
        p.has_exp = has_exp;
        p.exp = exp;
        dir_cases.push_back(p);
    endtask

    function automatic t_adv rand_adv();
        t_adv        p;
        logic [47:0] a;
        int          r;
        r = $urandom_range(0, 99);
        a = {$urandom, $urandom};
        p.en      = decode_on;
        p.id0     = COMPANY_ID_LO;
        p.id1     = COMPANY_ID_HI;
        p.addr    = ($urandom_range(0, 99) < 85) ? tag_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                 : a;
        p.rssi    = $urandom;
        p.now_ms  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom;
        p.v0      = ($urandom_range(0, 7) == 0) ? TEMP_MISSING : 16'($urandom);
        p.v1      = ($urandom_range(0, 7) == 0) ? RAW_MISSING : 16'($urandom);
        p.v2      = ($urandom_range(0, 7) == 0) ? RAW_MISSING : 16'($urandom);
        p.v3      = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            p.v3[15:5] = BATT_UNKNOWN;
        end
        p.has_exp = 1'b0;
        p.exp     = '0;
        if (r < 45) begin
            p.fmt = FMT_FIVE;
            p.len = ($urandom_range(0, 7) == 0) ? $urandom_range(27, 45) : 26;
        end else if (r < 80) begin
            p.fmt = FMT_THREE;
            p.len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : 16;
        end else begin
            p.fmt = FMT_FIVE;
            p.len = 26;
            case (t_flaw'($urandom_range(0, 5)))
                FLAW_ID_LO: begin
                    p.id0 = $urandom;
                end
                FLAW_ID_HI: begin
                    p.id1 = $urandom;
                end
                FLAW_HDR_ONLY: begin
                    p.len = $urandom_range(1, 3);
                end
                FLAW_SHORT_FIVE: begin
                    p.len = $urandom_range(3, 25);
                end
                FLAW_SHORT_THREE: begin
                    p.fmt = FMT_THREE;
                    p.len = $urandom_range(3, 15);
                end
                default: begin
                    p.fmt = $urandom;
                    p.len = $urandom_range(3, 40);
                end
            endcase
        end
        return p;
    endfunction

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_decode_enable(input bit v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        decode_on = v;
    endtask

    initial begin : record_sink
        t_result got;
        t_result want;
        int      stall_left;
        bit      rx_burst;
        stall_left = 0;
        rx_burst = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.stored                 = o_m_tdata[0];
                got.slot_index             = o_m_tdata[4:1];
                got.rec.is_format_five     = o_m_tuser;
                got.rec.temp_valid         = o_m_tdata[5];
                got.rec.temperature        = o_m_tdata[21:6];
                got.rec.humidity_valid     = o_m_tdata[22];
                got.rec.humidity           = o_m_tdata[38:23];
                got.rec.pressure_valid     = o_m_tdata[39];
                got.rec.pressure_pa        = o_m_tdata[56:40];
                got.rec.battery_mv         = o_m_tdata[72:57];
                got.rec.signal_out         = o_m_tdata[80:73];
                if (expected_records.size() == 0) begin
                    flag_error({"unexpected record: ", rec_str(got)});
                end else begin
                    want = expected_records.pop_front();
                    if (got !== want || o_m_tdata[87:81] !== 7'd0) begin
                        flag_error($sformatf("record mismatch at %0t\n  exp %s\n  got %s pad=%h",
                                             $realtime, rec_str(want), rec_str(got),
                                             o_m_tdata[87:81]));
                    end
                end
            end
            if ($urandom_range(0, 99) == 0) begin
                rx_burst = ($urandom_range(0, 2) == 0);
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
                stall_left = gap_cycles(rx_burst);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer in %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        bit en;
        int target;
        int k;

        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            tag_pool[i] = {$urandom, $urandom};
        end

        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_FIVE, 26, 16'h0000, 16'h0000, 16'h0000,
                16'h0000, 48'h0000_0000_0000, 8'h80, 32'd0, 1,
                '{1'b1, 4'd0, '{1'b1, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 17'd50000,
                                16'd1600, 8'h80}});
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_FIVE, 26, TEMP_MISSING, RAW_MISSING,
                RAW_MISSING, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 8'h7F, 32'hFFFF_FFFF, 1,
                '{1'b1, 4'd1, '{1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0, 17'd0,
                                16'd0, 8'h7F}});
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_FIVE, 26, 16'h7FFF, 16'hFFFE, 16'hFFFE,
                16'hFFDF, 48'h1234_5678_9ABC, 8'hC4, 32'd1000);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_FIVE, 26, 16'h8001, 16'h0001, 16'h0001,
                16'h001F, 48'h0000_0000_0001, 8'h00, 32'd2);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_THREE, 16, 16'hFFFF, 16'h00FF, 16'hFFFF,
                16'hFFFF, 48'h8000_0000_0000, 8'hFF, 32'd3);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_THREE, 16, 16'h7FFF, 16'h0064, 16'h0000,
                16'h0000, 48'hA5A5_A5A5_A5A5, 8'h01, 32'd4);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_THREE, 16, 16'h8000, 16'h0000, 16'h1234,
                16'h0BB8, 48'h5A5A_5A5A_5A5A, 8'hB0, 32'd5);
        add_row(1, 8'h98, COMPANY_ID_HI, FMT_FIVE, 26, 16'h1111, 16'h2222, 16'h3333,
                16'h4444, 48'h0, 8'h10, 32'd6, 1, '0);
        add_row(1, COMPANY_ID_LO, 8'h05, FMT_FIVE, 26, 16'h1111, 16'h2222, 16'h3333,
                16'h4444, 48'h0, 8'h10, 32'd7, 1, '0);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_FIVE, 2, 16'h0, 16'h0, 16'h0,
                16'h0, 48'h0, 8'h10, 32'd8, 1, '0);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_FIVE, 1, 16'h0, 16'h0, 16'h0,
                16'h0, 48'h0, 8'h10, 32'd9, 1, '0);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_FIVE, 3, 16'h0, 16'h0, 16'h0,
                16'h0, 48'h0, 8'h10, 32'd10, 1, '0);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_FIVE, 25, 16'h1111, 16'h2222, 16'h3333,
                16'h4444, 48'h0, 8'h10, 32'd11, 1, '0);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_THREE, 15, 16'h1111, 16'h2222, 16'h3333,
                16'h4444, 48'h0, 8'h10, 32'd12, 1, '0);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, 8'h04, 26, 16'h1111, 16'h2222, 16'h3333,
                16'h4444, 48'h0, 8'h10, 32'd13, 1, '0);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_FIVE, 40, 16'hFC18, 16'h9C40, 16'hC350,
                16'hB4A6, 48'hDEAD_BEEF_0042, 8'hD8, 32'd14);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_THREE, 33, 16'h8A63, 16'h0032, 16'h5DC0,
                16'h0C1C, 48'h0F0F_0F0F_0F0F, 8'hE2, 32'd15);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_FIVE, 26, 16'h0123, 16'h4567, 16'h89AB,
                16'hCDEF, 48'h0000_0000_0000, 8'h33, 32'd16);
        add_row(0, COMPANY_ID_LO, COMPANY_ID_HI, FMT_FIVE, 26, 16'h0123, 16'h4567, 16'h89AB,
                16'hCDEF, 48'h1111_2222_3333, 8'h33, 32'd17, 1, '0);
        add_row(0, COMPANY_ID_LO, COMPANY_ID_HI, FMT_THREE, 16, 16'h0123, 16'h4567, 16'h89AB,
                16'hCDEF, 48'h1111_2222_3333, 8'h33, 32'd18, 1, '0);
        add_row(1, COMPANY_ID_LO, COMPANY_ID_HI, FMT_THREE, 16, 16'h0456, 16'h0078, 16'h1000,
                16'h0BB8, 48'h1111_2222_3333, 8'h44, 32'd19);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_cases[i]) begin
            if (dir_cases[i].en != decode_on) begin
                set_decode_enable(dir_cases[i].en);
            end
            send_packet(dir_cases[i], 1'b0);
        end

        for (int ph = 0; ph < 6; ph++) begin
            en = !(ph == 1 || ph == 4);
            set_decode_enable(en);
            if (ph == 2) begin
                rx_hold_req = 1'b1;
            end
            target = bytes_sent + (en ? TOTAL_BYTES / 5 : TOTAL_BYTES / 10);
            k = 0;
            while (bytes_sent < target) begin
                send_packet(rand_adv(), ph == 2 && k < 12);
                k++;
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
